/* sv/sgr_pkg.sv */
// ----------------------------------------------------------------------------
// sgr_pkg
// Types, constants and codes shared by the scaled glyph pixel renderer.
// ----------------------------------------------------------------------------
package sgr_pkg;

   localparam int PANEL_WIDTH_DEFAULT  = 160;
   localparam int PANEL_HEIGHT_DEFAULT = 128;
   localparam int MAX_SCALE_DEFAULT    = 8;

   localparam int GLYPH_COLS = 5;
   localparam int GLYPH_ROWS = 7;
   localparam int GLYPH_BITS = GLYPH_COLS * GLYPH_ROWS;

   // Clipped cell sizes stay below 7 * 15 + 1 for any legal scale limit.
   localparam int DIM_W   = 7;
   localparam int SCALE_W = 4;
   localparam int COORD_W = 8;
   localparam int COLOR_W = 16;
   localparam int OFS_W   = 5;
   localparam int CSR_IDX_W = 1;

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_DRAW = 1'b1;

   localparam logic OUT_WINDOW = 1'b0;
   localparam logic OUT_PIXEL  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_OFFSET = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_OFFSET    = 1'b1;

   typedef enum logic [1:0] {
      OP_TICK,
      OP_DRAW,
      OP_SKIP
   } op_type;

   typedef struct packed {
      logic               kind;
      logic [8:0]         pos_x;
      logic [8:0]         pos_y;
      logic [7:0]         glyph_col0;
      logic [7:0]         glyph_col1;
      logic [7:0]         glyph_col2;
      logic [7:0]         glyph_col3;
      logic [7:0]         glyph_col4;
      logic [COLOR_W-1:0] fore_in;
      logic [COLOR_W-1:0] back_in;
      logic [SCALE_W-1:0] scale_in;
   } req_type;

   typedef struct packed {
      logic               out_kind;
      logic [COORD_W-1:0] x_first;
      logic [COORD_W-1:0] x_final;
      logic [COORD_W-1:0] y_first;
      logic [COORD_W-1:0] y_final;
      logic [COLOR_W-1:0] pixel_color;
      logic               last;
   } rsp_type;

   typedef struct packed {
      op_type                op;
      logic [GLYPH_BITS-1:0] glyph;
      logic [COLOR_W-1:0]    fore;
      logic [COLOR_W-1:0]    back;
      logic [SCALE_W-1:0]    scale;
      logic [DIM_W-1:0]      width;
      logic [DIM_W-1:0]      height;
      logic [COORD_W-1:0]    x_first;
      logic [COORD_W-1:0]    x_final;
      logic [COORD_W-1:0]    y_first;
      logic [COORD_W-1:0]    y_final;
   } entry_type;

endpackage

/* sv/sgr_front.sv */
// ----------------------------------------------------------------------------
// sgr_front
// Classifies incoming words, clamps the scale and clips the cell to the panel.
// ----------------------------------------------------------------------------
module sgr_front #(
   parameter int PANEL_WIDTH  = sgr_pkg::PANEL_WIDTH_DEFAULT,
   parameter int PANEL_HEIGHT = sgr_pkg::PANEL_HEIGHT_DEFAULT,
   parameter int MAX_SCALE    = sgr_pkg::MAX_SCALE_DEFAULT
) (
   input  sgr_pkg::req_type               req,
   input  logic [sgr_pkg::OFS_W-1:0]      column_offset,
   input  logic [sgr_pkg::OFS_W-1:0]      row_offset,
   output sgr_pkg::entry_type             entry
);
   import sgr_pkg::*;

   localparam logic [8:0]         PW   = 9'(PANEL_WIDTH);
   localparam logic [8:0]         PH   = 9'(PANEL_HEIGHT);
   localparam logic [SCALE_W-1:0] SMAX = SCALE_W'(MAX_SCALE);

   logic [SCALE_W-1:0] scale;
   logic [DIM_W-1:0]   w_full;
   logic [DIM_W-1:0]   h_full;
   logic [DIM_W-1:0]   w_clip;
   logic [DIM_W-1:0]   h_clip;
   logic [8:0]         x_end;
   logic [8:0]         y_end;
   logic [COORD_W-1:0] x8;
   logic [COORD_W-1:0] y8;

   always_comb begin
      if (req.scale_in == '0) begin
         scale = SCALE_W'(1);
      end else if (req.scale_in > SMAX) begin
         scale = SMAX;
      end else begin
         scale = req.scale_in;
      end
      w_full = DIM_W'(GLYPH_COLS) * DIM_W'(scale);
      h_full = DIM_W'(GLYPH_ROWS) * DIM_W'(scale);
      x_end  = req.pos_x + 9'(w_full);
      y_end  = req.pos_y + 9'(h_full);
      w_clip = (x_end > PW) ? DIM_W'(PW - req.pos_x) : w_full;
      h_clip = (y_end > PH) ? DIM_W'(PH - req.pos_y) : h_full;
      x8     = req.pos_x[COORD_W-1:0];
      y8     = req.pos_y[COORD_W-1:0];

      entry.glyph = {req.glyph_col4[6:0], req.glyph_col3[6:0], req.glyph_col2[6:0],
                     req.glyph_col1[6:0], req.glyph_col0[6:0]};
      entry.fore    = req.fore_in;
      entry.back    = req.back_in;
      entry.scale   = scale;
      entry.width   = w_clip;
      entry.height  = h_clip;
      entry.x_first = x8 + COORD_W'(column_offset);
      entry.x_final = x8 + COORD_W'(w_clip) - COORD_W'(1) + COORD_W'(column_offset);
      entry.y_first = y8 + COORD_W'(row_offset);
      entry.y_final = y8 + COORD_W'(h_clip) - COORD_W'(1) + COORD_W'(row_offset);

      if (req.kind == REQ_TICK) begin
         entry.op = OP_TICK;
      end else if (req.pos_x >= PW || req.pos_y >= PH) begin
         entry.op = OP_SKIP;
      end else begin
         entry.op = OP_DRAW;
      end
   end

endmodule

/* sv/sgr_queue.sv */
// ----------------------------------------------------------------------------
// sgr_queue
// Two-entry queue that decouples the front classifier from the pixel engine.
// ----------------------------------------------------------------------------
module sgr_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] head
);
   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* sv/sgr_back.sv */
// ----------------------------------------------------------------------------
// sgr_back
// Pixel engine: holds the character state, walks the cell and drives results.
// ----------------------------------------------------------------------------
module sgr_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  sgr_pkg::entry_type head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output sgr_pkg::rsp_type   rsp_data
);
   import sgr_pkg::*;

   logic                  busy_ff, busy_in;
   logic [GLYPH_BITS-1:0] glyph_ff, glyph_in;
   logic [COLOR_W-1:0]    fore_ff, fore_in;
   logic [COLOR_W-1:0]    back_ff, back_in;
   logic [SCALE_W-1:0]    scale_ff, scale_in;
   logic [DIM_W-1:0]      width_ff, width_in;
   logic [DIM_W-1:0]      height_ff, height_in;
   logic [DIM_W-1:0]      row_ff, row_in;
   logic [DIM_W-1:0]      col_ff, col_in;
   logic [SCALE_W-1:0]    row_sub_ff, row_sub_in;
   logic [SCALE_W-1:0]    col_sub_ff, col_sub_in;
   logic [2:0]            frow_ff, frow_in;
   logic [2:0]            fcol_ff, fcol_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [5:0] bit_idx;
   logic       lit;
   logic       fin;
   logic       row_end;

   assign pop       = head_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      bit_idx = 6'(fcol_ff) * 6'(GLYPH_ROWS) + 6'(frow_ff);
      lit     = glyph_ff[bit_idx];
      fin     = (row_ff + DIM_W'(1) >= height_ff) && (col_ff + DIM_W'(1) >= width_ff);
      row_end = (col_ff + DIM_W'(1) >= width_ff);

      busy_in    = busy_ff;
      glyph_in   = glyph_ff;
      fore_in    = fore_ff;
      back_in    = back_ff;
      scale_in   = scale_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      row_sub_in = row_sub_ff;
      col_sub_in = col_sub_ff;
      frow_in    = frow_ff;
      fcol_in    = fcol_ff;
      rsp_in     = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (pop) begin
         unique case (head.op)
            OP_DRAW: begin
               busy_in    = 1'b1;
               glyph_in   = head.glyph;
               fore_in    = head.fore;
               back_in    = head.back;
               scale_in   = head.scale;
               width_in   = head.width;
               height_in  = head.height;
               row_in     = '0;
               col_in     = '0;
               row_sub_in = '0;
               col_sub_in = '0;
               frow_in    = '0;
               fcol_in    = '0;
               rsp_valid_in = 1'b1;
               rsp_in = '{out_kind: OUT_WINDOW, x_first: head.x_first,
                          x_final: head.x_final, y_first: head.y_first,
                          y_final: head.y_final, pixel_color: '0, last: 1'b0};
            end
            OP_SKIP: begin
               busy_in = 1'b0;
            end
            OP_TICK: begin
               if (busy_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{out_kind: OUT_PIXEL, x_first: '0, x_final: '0,
                             y_first: '0, y_final: '0,
                             pixel_color: lit ? fore_ff : back_ff, last: fin};
                  if (fin) begin
                     busy_in = 1'b0;
                  end else if (row_end) begin
                     col_in     = '0;
                     col_sub_in = '0;
                     fcol_in    = '0;
                     row_in     = row_ff + DIM_W'(1);
                     if (row_sub_ff == scale_ff - SCALE_W'(1)) begin
                        row_sub_in = '0;
                        frow_in    = frow_ff + 3'd1;
                     end else begin
                        row_sub_in = row_sub_ff + SCALE_W'(1);
                     end
                  end else begin
                     col_in = col_ff + DIM_W'(1);
                     if (col_sub_ff == scale_ff - SCALE_W'(1)) begin
                        col_sub_in = '0;
                        fcol_in    = fcol_ff + 3'd1;
                     end else begin
                        col_sub_in = col_sub_ff + SCALE_W'(1);
                     end
                  end
               end
            end
            default: begin
               busy_in = busy_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      glyph_ff   <= glyph_in;
      fore_ff    <= fore_in;
      back_ff    <= back_in;
      scale_ff   <= scale_in;
      width_ff   <= width_in;
      height_ff  <= height_in;
      row_ff     <= row_in;
      col_ff     <= col_in;
      row_sub_ff <= row_sub_in;
      col_sub_ff <= col_sub_in;
      frow_ff    <= frow_in;
      fcol_ff    <= fcol_in;
      rsp_ff     <= rsp_in;
   end

endmodule

/* sv/scaled_glyph_pixel_renderer_top.sv */
// ----------------------------------------------------------------------------
// scaled_glyph_pixel_renderer_top
// Renders a scaled 5x7 glyph into an address window and a pixel stream.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (req_valid/req_ready/req_data) takes one word per
// accepted handshake. A draw word carries position, glyph columns, colors and
// scale; a tick word asks for the next pixel of the character in progress.
// A draw on the panel answers with one window word on the response channel
// (rsp_valid/rsp_ready/rsp_data); a draw off the panel answers nothing and
// drops any character in progress. Each tick while a character is active
// answers with one pixel word, row by row, with last set on the final pixel.
// Ticks while idle are absorbed silently.
// A word accepted into the queue is popped by the pixel engine, and its response
// word goes into the response register. While the receiver is ready the rate is
// one word per cycle, set by the pixel engine retiring one queue entry per cycle.
// A two-entry queue sits between classifier and pixel engine, so when the
// receiver stalls the queue fills and then req_ready drops; nothing is lost.
// Reset clears the queue, the response register and the busy flag, and
// restores the column offset to 3 and the row offset to 1. The user must write the
// offsets through the csr_ port only while the block is idle; it does not check.
// ----------------------------------------------------------------------------
module scaled_glyph_pixel_renderer_top #(
   parameter int PANEL_WIDTH  = sgr_pkg::PANEL_WIDTH_DEFAULT,
   parameter int PANEL_HEIGHT = sgr_pkg::PANEL_HEIGHT_DEFAULT,
   parameter int MAX_SCALE    = sgr_pkg::MAX_SCALE_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  sgr_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output sgr_pkg::rsp_type                  rsp_data,
   input  logic                              csr_write_en,
   input  logic [sgr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sgr_pkg::OFS_W-1:0]         csr_wdata
);
   import sgr_pkg::*;

   // Offset registers written by the configuration port.
   logic [OFS_W-1:0] col_ofs_ff, col_ofs_in;
   logic [OFS_W-1:0] row_ofs_ff, row_ofs_in;

   entry_type new_entry;
   entry_type head_entry;
   logic      queue_full;
   logic      queue_push;
   logic      head_valid;
   logic      head_pop;

   always_comb begin
      col_ofs_in = col_ofs_ff;
      row_ofs_in = row_ofs_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_COLUMN_OFFSET: col_ofs_in = csr_wdata;
            CSR_ROW_OFFSET:    row_ofs_in = csr_wdata;
            default:           col_ofs_in = col_ofs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ofs_ff <= OFS_W'(3);
         row_ofs_ff <= OFS_W'(1);
      end else begin
         col_ofs_ff <= col_ofs_in;
         row_ofs_ff <= row_ofs_in;
      end
   end

   // A word is taken whenever the queue has room.
   assign req_ready  = !queue_full;
   assign queue_push = req_valid && req_ready;

   sgr_front #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT),
      .MAX_SCALE    (MAX_SCALE)
   ) u_front (
      .req           (req_data),
      .column_offset (col_ofs_ff),
      .row_offset    (row_ofs_ff),
      .entry         (new_entry)
   );

   sgr_queue #(
      .WIDTH ($bits(entry_type))
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (new_entry),
      .full      (queue_full),
      .pop       (head_pop),
      .not_empty (head_valid),
      .head      (head_entry)
   );

   sgr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head_entry),
      .pop        (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

/* sv/sgr_checker.sv */
// ----------------------------------------------------------------------------
// sgr_checker
// Port-level checks for the scaled glyph pixel renderer, bound to the top.
// ----------------------------------------------------------------------------
module sgr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input sgr_pkg::rsp_type              rsp_data
);
   import sgr_pkg::*;

   // A stalled response word holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // Reset empties the response register and the queue.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not empty right after reset");

   // A waiting request word stays offered until it is taken.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("request withdrawn before it was taken");

   // Window words carry no pixel color and no last flag.
   a_window_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_kind == OUT_WINDOW |->
         rsp_data.pixel_color == '0 && !rsp_data.last)
      else $error("window word with pixel fields set");

   // Pixel words carry no window coordinates.
   a_pixel_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_kind == OUT_PIXEL |->
         rsp_data.x_first == '0 && rsp_data.x_final == '0 &&
         rsp_data.y_first == '0 && rsp_data.y_final == '0)
      else $error("pixel word with window fields set");

endmodule

bind scaled_glyph_pixel_renderer_top sgr_checker u_sgr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the scaled glyph pixel renderer. Draw and tick words
// are pushed through the request channel with random gaps, a scoreboard
// predicts every window and pixel word, and each response word is compared
// field by field as it leaves under random backpressure; calm turns both off.
// ----------------------------------------------------------------------------

// Scoreboard: keeps its own copy of the renderer state and the expected words.
class glyph_scoreboard;
   logic [sgr_pkg::OFS_W-1:0]      col_ofs;
   logic [sgr_pkg::OFS_W-1:0]      row_ofs;
   logic [sgr_pkg::GLYPH_BITS-1:0] glyph;
   logic [sgr_pkg::COLOR_W-1:0]    fore;
   logic [sgr_pkg::COLOR_W-1:0]    back;
   int unsigned                    scale;
   int unsigned                    width;
   int unsigned                    height;
   int unsigned                    row;
   int unsigned                    col;
   bit                             active;
   sgr_pkg::rsp_type               expected_words[$];
   int unsigned                    words_predicted;
   int unsigned                    windows_seen;
   int unsigned                    pixels_seen;
   int unsigned                    mismatches;

   function new();
      col_ofs = 3;
      row_ofs = 1;
      glyph = '0;
      fore = '0;
      back = '0;
      scale = 1;
      width = 0;
      height = 0;
      row = 0;
      col = 0;
      active = 1'b0;
      words_predicted = 0;
      windows_seen = 0;
      pixels_seen = 0;
      mismatches = 0;
   endfunction

   function void set_offsets(logic [sgr_pkg::OFS_W-1:0] c, logic [sgr_pkg::OFS_W-1:0] r);
      col_ofs = c;
      row_ofs = r;
   endfunction

   // Pixels still owed for the character in progress.
   function int unsigned pixels_left();
      return active ? (height - row) * width - col : 0;
   endfunction

   function void note_request(sgr_pkg::req_type w);
      sgr_pkg::rsp_type e;
      int unsigned      x;
      int unsigned      y;
      int unsigned      frow;
      int unsigned      fcol;
      bit               lit;
      bit               fin;
      e = '0;
      if (w.kind == sgr_pkg::REQ_DRAW) begin
         active = 1'b0;
         x = w.pos_x;
         y = w.pos_y;
         if (x >= sgr_pkg::PANEL_WIDTH_DEFAULT || y >= sgr_pkg::PANEL_HEIGHT_DEFAULT) return;
         scale = w.scale_in;
         if (scale == 0) scale = 1;
         if (scale > sgr_pkg::MAX_SCALE_DEFAULT) scale = sgr_pkg::MAX_SCALE_DEFAULT;
         glyph = {w.glyph_col4[6:0], w.glyph_col3[6:0], w.glyph_col2[6:0],
                  w.glyph_col1[6:0], w.glyph_col0[6:0]};
         fore = w.fore_in;
         back = w.back_in;
         width = sgr_pkg::GLYPH_COLS * scale;
         height = sgr_pkg::GLYPH_ROWS * scale;
         if (x + width > sgr_pkg::PANEL_WIDTH_DEFAULT) width = sgr_pkg::PANEL_WIDTH_DEFAULT - x;
         if (y + height > sgr_pkg::PANEL_HEIGHT_DEFAULT)
            height = sgr_pkg::PANEL_HEIGHT_DEFAULT - y;
         row = 0;
         col = 0;
         active = 1'b1;
         // Only the low byte of each bound survives.
         e.out_kind = sgr_pkg::OUT_WINDOW;
         e.x_first = 8'(x + col_ofs);
         e.x_final = 8'(x + width - 1 + col_ofs);
         e.y_first = 8'(y + row_ofs);
         e.y_final = 8'(y + height - 1 + row_ofs);
         expected_words.push_back(e);
         words_predicted++;
      end else if (active) begin
         frow = row / scale;
         fcol = col / scale;
         lit = 1'b0;
         if (frow < sgr_pkg::GLYPH_ROWS && fcol < sgr_pkg::GLYPH_COLS)
            lit = glyph[fcol * sgr_pkg::GLYPH_ROWS + frow];
         fin = (row + 1 >= height) && (col + 1 >= width);
         e.out_kind = sgr_pkg::OUT_PIXEL;
         e.pixel_color = lit ? fore : back;
         e.last = fin;
         expected_words.push_back(e);
         words_predicted++;
         if (fin) begin
            active = 1'b0;
            row = 0;
            col = 0;
         end else begin
            col++;
            if (col >= width) begin
               col = 0;
               row++;
            end
         end
      end
   endfunction

   function void check_response(sgr_pkg::rsp_type got);
      sgr_pkg::rsp_type want;
      if (expected_words.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR %0t: unexpected word kind=%0d x=%0d..%0d y=%0d..%0d color=%h last=%0d",
                     $time, got.out_kind, got.x_first, got.x_final, got.y_first, got.y_final,
                     got.pixel_color, got.last);
         return;
      end
      want = expected_words.pop_front();
      if (got.out_kind !== want.out_kind || got.x_first !== want.x_first ||
          got.x_final !== want.x_final || got.y_first !== want.y_first ||
          got.y_final !== want.y_final || got.pixel_color !== want.pixel_color ||
          got.last !== want.last) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("ERROR %0t: expected kind=%0d x=%0d..%0d y=%0d..%0d color=%h last=%0d",
                     $time, want.out_kind, want.x_first, want.x_final, want.y_first,
                     want.y_final, want.pixel_color, want.last);
            $display("          actual   kind=%0d x=%0d..%0d y=%0d..%0d color=%h last=%0d",
                     got.out_kind, got.x_first, got.x_final, got.y_first, got.y_final,
                     got.pixel_color, got.last);
         end
      end else if (want.out_kind == sgr_pkg::OUT_WINDOW) begin
         windows_seen++;
      end else begin
         pixels_seen++;
      end
   endfunction
endclass

module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sgr_pkg::*;

   // A stretch this long without any handshake or register write means a hang.
   localparam int STALL_LIMIT = 2000;
   // Margin for the response latency and for a tick that is absorbed silently.
   localparam int SETTLE_CYCLES = 8;
   localparam int WORDS_PER_PHASE = 210;
   localparam int PW = PANEL_WIDTH_DEFAULT;
   localparam int PH = PANEL_HEIGHT_DEFAULT;
   localparam int REQ_W = $bits(req_type);

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_COLUMN_OFFSET;
   logic [OFS_W-1:0]     csr_wdata = '0;

   // When calm is set neither side inserts idle cycles.
   bit                   calm = 1'b0;
   int unsigned          stall_cycles = 0;
   int unsigned          settings_run = 1;
   glyph_scoreboard      sb;

   scaled_glyph_pixel_renderer_top uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The receiver stalls in about a quarter of the cycles unless calm is set.
   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 27);
   end

   // Monitor: both channels are sampled at the rising edge. The response is
   // checked before the request is noted, since a word accepted at this edge
   // can never be answered at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
         if (req_valid && req_ready) sb.note_request(req_data);
      end
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en)
         stall_cycles = 0;
      else
         stall_cycles++;
   end

   initial begin : watchdog
      wait (stall_cycles >= STALL_LIMIT);
      $display("Timeout: no handshake for %0d cycles, %0d words still expected",
               STALL_LIMIT, sb.expected_words.size());
      $display("CHECKS FAILED");
      $finish;
   end

   // Any field may hold anything; kind and the rest are filled in afterwards.
   function automatic req_type random_word();
      req_type w;
      w = REQ_W'({$urandom, $urandom, $urandom});
      return w;
   endfunction

   function automatic req_type tick_word();
      req_type w;
      w = random_word();
      w.kind = REQ_TICK;
      return w;
   endfunction

   function automatic req_type draw_word(int unsigned x, int unsigned y, int unsigned s);
      req_type w;
      w = random_word();
      w.kind = REQ_DRAW;
      w.pos_x = 9'(x);
      w.pos_y = 9'(y);
      w.scale_in = 4'(s);
      return w;
   endfunction

   // A draw with every glyph column equal and fixed colors, for the directed part.
   function automatic req_type draw_fixed(int unsigned x, int unsigned y, int unsigned s,
                                          logic [7:0] column, logic [15:0] fg, logic [15:0] bg);
      req_type w;
      w = draw_word(x, y, s);
      w.glyph_col0 = column;
      w.glyph_col1 = column;
      w.glyph_col2 = column;
      w.glyph_col3 = column;
      w.glyph_col4 = column;
      w.fore_in = fg;
      w.back_in = bg;
      return w;
   endfunction

   // Called at a falling edge. Holds the word until it is taken, then may idle.
   // Valid is never lowered and raised again in the same step: a following
   // word simply overwrites the payload while valid stays high.
   task automatic send_word(input req_type w);
      req_data = w;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (!calm) begin
         while ($urandom_range(99) < 27) begin
            req_valid = 1'b0;
            req_data = random_word();
            @(negedge clock);
         end
      end
   endtask

   // Stop sending until every expected word has come back, then let a few
   // more cycles pass in case a silently absorbed word is still in flight.
   task automatic drain();
      req_valid = 1'b0;
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Both offsets, one per cycle. Only called right after a drain.
   task automatic write_offsets(input logic [OFS_W-1:0] c, input logic [OFS_W-1:0] r);
      csr_write_en = 1'b1;
      csr_index = CSR_COLUMN_OFFSET;
      csr_wdata = c;
      @(negedge clock);
      csr_index = CSR_ROW_OFFSET;
      csr_wdata = r;
      @(negedge clock);
      csr_write_en = 1'b0;
      sb.set_offsets(c, r);
      settings_run++;
   endtask

   // One character drawn on the panel and ticked out, sometimes abandoned early.
   // Big scales are placed against an edge so the clipped cell stays small.
   task automatic random_character();
      int unsigned pick;
      int unsigned s;
      int unsigned x;
      int unsigned y;
      int unsigned left;
      pick = $urandom_range(99);
      if (pick < 50) s = $urandom_range(1);
      else if (pick < 70) s = 2;
      else s = $urandom_range(15, 3);
      x = $urandom_range(PW - 1);
      y = $urandom_range(PH - 1);
      if (s >= 3) begin
         if ($urandom_range(1)) x = $urandom_range(PW - 1, PW - 8);
         else y = $urandom_range(PH - 1, PH - 8);
      end
      send_word(draw_word(x, y, s));
      left = sb.pixels_left();
      if ($urandom_range(99) < 30) left = $urandom_range(left);
      repeat (left) send_word(tick_word());
   endtask

   // A mix of well-formed characters and noise until the phase has produced
   // its share of response words.
   task automatic random_phase();
      int unsigned goal;
      int unsigned pick;
      goal = sb.words_predicted + WORDS_PER_PHASE;
      while (sb.words_predicted < goal) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            random_character();
         end else if (pick < 80) begin
            // Off the panel: drops whatever is in progress.
            if ($urandom_range(1))
               send_word(draw_word($urandom_range(511, PW), $urandom_range(511),
                                   $urandom_range(15)));
            else
               send_word(draw_word($urandom_range(511), $urandom_range(511, PH),
                                   $urandom_range(15)));
         end else if (pick < 92) begin
            send_word(random_word());
         end else if (pick < 97) begin
            send_word(tick_word());
         end else begin
            drain();
         end
      end
   endtask

   initial begin : stimulus
      sb = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, with the offsets still at their reset values.
      // A tick with nothing in progress is absorbed.
      send_word(tick_word());
      // Scale zero in the bottom-right corner gives a single lit pixel; bit 7
      // of each column is set as well and must not matter.
      send_word(draw_fixed(PW - 1, PH - 1, 0, 8'hFF, 16'hFFFF, 16'h0000));
      send_word(tick_word());
      // The character is complete, so this tick is absorbed too.
      send_word(tick_word());
      // Scale above the limit, clipped to two by two; only bit 7 set means unlit.
      send_word(draw_fixed(PW - 2, PH - 2, 15, 8'h80, 16'h0000, 16'hFFFF));
      send_word(tick_word());
      send_word(tick_word());
      // A new draw while busy restarts at the top-left corner.
      send_word(draw_word(0, 0, 9));
      send_word(tick_word());
      send_word(tick_word());
      // Draws just past each edge and at the far extreme give nothing.
      send_word(draw_word(PW, 0, 1));
      send_word(tick_word());
      send_word(draw_word(0, PH, 1));
      send_word(draw_fixed(511, 511, 15, 8'h7F, 16'hFFFF, 16'hFFFF));
      // One row of a scale-one glyph with equal columns, all lit, last on the fifth.
      send_word(draw_fixed(PW - 5, PH - 1, 1, 8'h55, 16'hA5A5, 16'h5A5A));
      repeat (5) send_word(tick_word());
      send_word(draw_fixed(0, PH - 1, 2, 8'h01, 16'hFFFF, 16'h0000));
      send_word(tick_word());

      // Random phases, each with its own offset setting. The third phase runs
      // with no idling on either side.
      random_phase();
      drain();
      write_offsets(5'd0, 5'd0);
      random_phase();
      drain();
      write_offsets(5'd31, 5'd31);
      calm = 1'b1;
      random_phase();
      drain();
      calm = 1'b0;
      write_offsets(OFS_W'($urandom_range(31)), OFS_W'($urandom_range(31)));
      random_phase();
      drain();
      write_offsets(5'd0, 5'd31);
      random_phase();

      drain();
      $display("Checked %0d window words and %0d pixel words under %0d offset settings.",
               sb.windows_seen, sb.pixels_seen, settings_run);
      $display("Mismatches: %0d, words still expected: %0d.",
               sb.mismatches, sb.expected_words.size());
      if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
sv/sgr_pkg.sv
sv/sgr_front.sv
sv/sgr_queue.sv
sv/sgr_back.sv
sv/scaled_glyph_pixel_renderer_top.sv
sv/sgr_checker.sv
sim/tb.sv
